// ----- sv/quaternion_orientation_update_defines.svh -----
// Assertion macros for the quaternion orientation update block
`ifndef QUATERNION_ORIENTATION_UPDATE_DEFINES_SVH
`define QUATERNION_ORIENTATION_UPDATE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define QOU_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define QOU_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- sv/qou_pkg.sv -----
// Types and constants of the quaternion orientation update block
package qou_pkg;
	localparam int ATAN_COUNT = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef enum logic [1:0] {
		KIND_ROTATE = 2'd0,
		KIND_RENORM = 2'd1,
		KIND_IDENT  = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_AXIS, ST_PROD, ST_LEN, ST_SQRT, ST_DIV, ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] out_w;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
	} out_word_t;

	function automatic logic [31:0] atan_rom(input logic [4:0] i);
		case (i)
			5'd0: atan_rom = 32'h20000000;  5'd1: atan_rom = 32'h12E4051E;
			5'd2: atan_rom = 32'h09FB385B;  5'd3: atan_rom = 32'h051111D4;
			5'd4: atan_rom = 32'h028B0D43;  5'd5: atan_rom = 32'h0145D7E1;
			5'd6: atan_rom = 32'h00A2F61E;  5'd7: atan_rom = 32'h00517C55;
			5'd8: atan_rom = 32'h0028BE53;  5'd9: atan_rom = 32'h00145F2F;
			5'd10: atan_rom = 32'h000A2F98; 5'd11: atan_rom = 32'h000517CC;
			5'd12: atan_rom = 32'h00028BE6; 5'd13: atan_rom = 32'h000145F3;
			5'd14: atan_rom = 32'h0000A2FA; 5'd15: atan_rom = 32'h0000517D;
			5'd16: atan_rom = 32'h000028BE; 5'd17: atan_rom = 32'h0000145F;
			5'd18: atan_rom = 32'h00000A30; 5'd19: atan_rom = 32'h00000518;
			5'd20: atan_rom = 32'h0000028C; 5'd21: atan_rom = 32'h00000146;
			5'd22: atan_rom = 32'h000000A3; 5'd23: atan_rom = 32'h00000051;
			default: atan_rom = 32'h0;
		endcase
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) sat16 = 16'sh7FFF;
		else if (v < -48'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction
endpackage

// ----- sv/qou_stream_if.sv -----
// Valid/ready stream interface
interface qou_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/qou_mac.sv -----
// Shared multiply-accumulate unit: one signed 17x17 product per cycle
module qou_mac (
	input  logic               clk,
	input  logic               clr,
	input  logic               en,
	input  logic               neg,
	input  logic signed [16:0] a,
	input  logic signed [16:0] b,
	output logic signed [47:0] acc
);
	logic signed [33:0] prod_s1;
	logic               neg_s1;
	logic               en_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		neg_s1  <= neg;
		en_s1   <= en;
		if (clr)
			acc <= '0;
		else if (en_s1)
			acc <= neg_s1 ? acc - 48'(prod_s1) : acc + 48'(prod_s1);
	end
endmodule

// ----- sv/quaternion_orientation_update.sv -----
// Quaternion orientation update top level
// channel | dir | payload
// in_ch   | in  | kind, angle, axis_x, axis_y, axis_z
// out_ch  | out | out_w, out_x, out_y, out_z
// Rotate: CORDIC_STEPS CORDIC steps, then axis products, quaternion product and the load of
// the output register. Renormalise: sum of squares, 25 root steps, 4 divisions, then the load.
// Zero length goes straight to done, as do identity and no-op. Ready again as the output
// register is loaded.
// Ready only in idle; a result holds in its output register until taken, and a second
// finished word holds in done. Reset loads identity.
module quaternion_orientation_update #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	qou_stream_if.sink   in_ch,
	qou_stream_if.source out_ch
);
	import qou_pkg::*;
	`include "quaternion_orientation_update_defines.svh"

	state_t state_q, state_d;
	logic signed [15:0] q_q [4];
	logic signed [15:0] b_q [4];
	logic signed [15:0] p_q [4];
	in_word_t in_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [5:0] cnt_q;
	logic [1:0] sub_q;
	logic [49:0] rem_q;
	logic [25:0] root_q;
	logic [41:0] num_q;
	logic [41:0] quo_q;
	logic out_valid_q;
	out_word_t out_q;

	logic mac_clr, mac_en, mac_neg;
	logic signed [16:0] mac_a, mac_b;
	logic signed [47:0] acc;

	qou_mac u_mac (.clk, .clr(mac_clr), .en(mac_en), .neg(mac_neg),
		.a(mac_a), .b(mac_b), .acc);

	// product schedule: output k, term t -> operand index of q and b, sign
	function automatic logic [4:0] sched(input logic [1:0] k, input logic [1:0] t);
		logic [1:0] qi, bi; logic n;
		qi = t; n = 1'b0; bi = 2'd0;
		case (k)
			2'd0: begin bi = t; n = (t != 2'd0); end
			2'd1: case (t)
				2'd0: bi = 2'd1; 2'd1: bi = 2'd0; 2'd2: bi = 2'd3;
				default: begin bi = 2'd2; n = 1'b1; end endcase
			2'd2: case (t)
				2'd0: bi = 2'd2; 2'd1: begin bi = 2'd3; n = 1'b1; end
				2'd2: bi = 2'd0; default: bi = 2'd1; endcase
			default: case (t)
				2'd0: bi = 2'd3; 2'd1: bi = 2'd2; 2'd2: begin bi = 2'd1; n = 1'b1; end
				default: bi = 2'd0; endcase
		endcase
		sched = {qi, bi, n};
	endfunction

	logic [4:0] sc;
	logic [1:0] kidx;
	logic signed [33:0] sin_r, cos_r;
	logic signed [47:0] rnd;

	always_comb begin
		sc = sched(cnt_q[3:2], cnt_q[1:0]);
		kidx = cnt_q[1:0];
		cos_r = (cx_q + 34'sd32768) >>> 16;
		sin_r = (cy_q + 34'sd32768) >>> 16;
		rnd = (acc + 48'sd8192) >>> 14;
	end

	always_comb begin
		mac_clr = 1'b0; mac_en = 1'b0; mac_neg = 1'b0;
		mac_a = '0; mac_b = '0;
		case (state_q)
			ST_AXIS: begin
				mac_clr = (sub_q == 2'd0);
				mac_en = (sub_q == 2'd0) && (cnt_q < 6'd3);
				mac_b = 17'(sin_r);
				case (cnt_q[1:0])
					2'd0: mac_a = 17'(in_q.axis_x);
					2'd1: mac_a = 17'(in_q.axis_y);
					default: mac_a = 17'(in_q.axis_z);
				endcase
			end
			ST_PROD: begin
				mac_clr = (sub_q == 2'd3) || (cnt_q[1:0] == 2'd0 && sub_q == 2'd0);
				mac_en = (sub_q == 2'd0);
				mac_neg = sc[0];
				mac_a = 17'(q_q[sc[4:3]]);
				mac_b = 17'(b_q[sc[2:1]]);
			end
			ST_LEN: begin
				mac_clr = (cnt_q == 6'd0) && (sub_q == 2'd0);
				mac_en = (sub_q == 2'd0) && (cnt_q < 6'd4);
				mac_a = 17'(q_q[kidx]);
				mac_b = 17'(q_q[kidx]);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) begin
				case (kind_t'(in_ch.data.kind))
					KIND_ROTATE: state_d = ST_CORDIC;
					KIND_RENORM: state_d = ST_LEN;
					default: state_d = ST_DONE;
				endcase
			end
			ST_CORDIC: if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = ST_AXIS;
			ST_AXIS: if (cnt_q == 6'd2 && sub_q == 2'd2) state_d = ST_PROD;
			ST_PROD: if (cnt_q == 6'd16 && sub_q == 2'd3) state_d = ST_DONE;
			ST_LEN: if (cnt_q == 6'd3 && sub_q == 2'd2)
				state_d = (acc == 48'sd0) ? ST_DONE : ST_SQRT;
			ST_SQRT: if (cnt_q == 6'd24) state_d = ST_DIV;
			ST_DIV: if (cnt_q == 6'd43 && sub_q == 2'd3) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			q_q[0] <= ONE_Q14; q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
			cnt_q <= '0; sub_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					in_q <= in_ch.data;
					cx_q <= CORDIC_GAIN; cy_q <= '0;
					cz_q <= 34'(in_ch.data.angle) <<< 15;
					cnt_q <= '0; sub_q <= '0;
					if (kind_t'(in_ch.data.kind) == KIND_IDENT) begin
						q_q[0] <= ONE_Q14; q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
					end
				end
				ST_CORDIC: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - (cy_q >>> cnt_q[4:0]);
						cy_q <= cy_q + (cx_q >>> cnt_q[4:0]);
						cz_q <= cz_q - 34'(atan_rom(cnt_q[4:0]));
					end else begin
						cx_q <= cx_q + (cy_q >>> cnt_q[4:0]);
						cy_q <= cy_q - (cx_q >>> cnt_q[4:0]);
						cz_q <= cz_q + 34'(atan_rom(cnt_q[4:0]));
					end
					cnt_q <= (cnt_q == 6'(CORDIC_STEPS - 1)) ? 6'd0 : cnt_q + 6'd1;
				end
				ST_AXIS: begin
					b_q[0] <= sat16(48'(cos_r));
					if (sub_q == 2'd2) begin
						b_q[cnt_q[1:0] + 2'd1] <= sat16(rnd);
						sub_q <= '0;
						cnt_q <= (cnt_q == 6'd2) ? 6'd0 : cnt_q + 6'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_PROD: begin
					// four terms per component, wait through the MAC product and accumulator registers, store, clear
					if (sub_q == 2'd0) begin
						if (cnt_q[1:0] == 2'd3) sub_q <= 2'd1;
						else cnt_q <= cnt_q + 6'd1;
					end else if (sub_q == 2'd1) begin
						sub_q <= 2'd2;
					end else if (sub_q == 2'd2) begin
						p_q[cnt_q[3:2]] <= sat16(rnd);
						sub_q <= 2'd3;
						cnt_q <= cnt_q + 6'd1;
					end else begin
						sub_q <= 2'd0;
						if (cnt_q == 6'd16) begin
							q_q[0] <= p_q[0]; q_q[1] <= p_q[1];
							q_q[2] <= p_q[2]; q_q[3] <= p_q[3];
						end
					end
				end
				ST_LEN: begin
					if (cnt_q < 6'd3) begin
						cnt_q <= cnt_q + 6'd1;
					end else if (sub_q == 2'd2) begin
						rem_q <= 50'(acc) << 16;
						root_q <= '0;
						cnt_q <= '0; sub_q <= '0;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_SQRT: begin
					// bit pair per step, bit weight 4^(24-cnt)
					if (rem_q >= ((50'(root_q) << (6'd25 - cnt_q))
						+ (50'd1 << (6'd48 - {cnt_q[4:0], 1'b0})))) begin
						rem_q <= rem_q - ((50'(root_q) << (6'd25 - cnt_q))
							+ (50'd1 << (6'd48 - {cnt_q[4:0], 1'b0})));
						root_q <= root_q | (26'd1 << (6'd24 - cnt_q));
					end
					if (cnt_q == 6'd24) begin
						cnt_q <= '0; sub_q <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 6'd0) begin
						num_q <= (42'(q_q[sub_q][15] ? -17'(q_q[sub_q]) : 17'(q_q[sub_q]))
							<< 22) + 42'(root_q >> 1);
						quo_q <= '0;
						cnt_q <= 6'd1;
					end else if (cnt_q < 6'd43) begin
						if ({quo_q[40:0], num_q[41]} >= 42'(root_q))
							quo_q <= {quo_q[40:0], num_q[41]} - 42'(root_q);
						else
							quo_q <= {quo_q[40:0], num_q[41]};
						num_q <= {num_q[40:0],
							({quo_q[40:0], num_q[41]} >= 42'(root_q))};
						cnt_q <= cnt_q + 6'd1;
					end else begin
						q_q[sub_q] <= q_q[sub_q][15] ? sat16(-$signed(48'(num_q)))
							: sat16($signed(48'(num_q)));
						sub_q <= sub_q + 2'd1;
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
				out_q <= '{out_w: q_q[0], out_x: q_q[1], out_y: q_q[2], out_z: q_q[3]};
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`QOU_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ch.ready, !out_valid_q || state_q == ST_IDLE)
	`QOU_ASSERT_NXT(a_accept_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	`QOU_ASSERT_NXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
endmodule
